[rtl/core/bpfd_pkg.sv]
package bpfd_pkg;

  localparam int unsigned PageW  = 24;
  localparam int unsigned PinW   = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned TotW   = 32;
  localparam int unsigned MaxRsp = 16;

  localparam logic [2:0] REQ_PIN   = 3'd0;
  localparam logic [2:0] REQ_UNPIN = 3'd1;
  localparam logic [2:0] REQ_DIRTY = 3'd2;
  localparam logic [2:0] REQ_FORCE = 3'd3;
  localparam logic [2:0] REQ_FLUSH = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_NO_VICT  = 2'd2;

  localparam logic [0:0] REG_MODE   = 1'b0;
  localparam logic [0:0] REG_FRAMES = 1'b1;

  localparam logic [PinW-1:0]   PIN_MAX = '1;
  localparam logic [TotW-1:0]   TOT_MAX = '1;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [PageW-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [3:0]       frame_index;
    logic [1:0]       status;
    logic             was_hit;
    logic             fetch_page;
    logic             write_back;
    logic [PageW-1:0] write_page_number;
    logic [TotW-1:0]  read_total;
    logic [TotW-1:0]  write_total;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [PageW-1:0]  page;
    logic [PinW-1:0]   pin;
    logic              dirty;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              hit_found;
    logic [7:0]        hit_idx;
    logic              empty_found;
    logic [7:0]        empty_idx;
    logic              lru_found;
    logic [7:0]        lru_idx;
    logic [StampW-1:0] lru_stamp;
    logic              ffhi_found;
    logic [7:0]        ffhi_idx;
    logic              fflo_found;
    logic [7:0]        fflo_idx;
  } scan_t;

endpackage

[rtl/core/bpfd_scan.sv]
module bpfd_scan
  import bpfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             en_i,
  input  logic [7:0]       idx_i,
  input  logic             vld_i,
  input  entry_t           ent_i,
  input  logic [PageW-1:0] page_i,
  input  logic [7:0]       start_i,
  output scan_t            res_o
);

  scan_t             res_q, res_d;
  logic              unpinned;
  logic [StampW-1:0] stamp;

  assign unpinned = !vld_i || (ent_i.pin == '0);
  assign stamp    = vld_i ? ent_i.stamp : '0;

  always_comb begin
    res_d = res_q;
    if (clr_i) begin
      res_d = '0;
    end else if (en_i) begin
      if (vld_i && (ent_i.page == page_i) && !res_q.hit_found) begin
        res_d.hit_found = 1'b1;
        res_d.hit_idx   = idx_i;
      end
      if (!vld_i && !res_q.empty_found) begin
        res_d.empty_found = 1'b1;
        res_d.empty_idx   = idx_i;
      end
      // strict compare keeps the lowest index on a tie
      if (unpinned && (!res_q.lru_found || (stamp < res_q.lru_stamp))) begin
        res_d.lru_found = 1'b1;
        res_d.lru_idx   = idx_i;
        res_d.lru_stamp = stamp;
      end
      if (unpinned && (idx_i >= start_i) && !res_q.ffhi_found) begin
        res_d.ffhi_found = 1'b1;
        res_d.ffhi_idx   = idx_i;
      end
      if (unpinned && !res_q.fflo_found) begin
        res_d.fflo_found = 1'b1;
        res_d.fflo_idx   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/core/buffer_pool_frame_directory_top.sv]
// Channel | Dir | Signals                        | Beat
// req     | in  | req_valid_i, req_ready_o, req_i | one request
// rsp     | out | rsp_valid_o, rsp_ready_i, rsp_o | one result
// cfg     | in  | psel, penable, pwrite, paddr... | one register access
// A request with n active frames makes one memory read per frame through the single read
// port, then a read of the chosen frame and a write to it unless the result is an error.
// Flush reads each active frame in turn, cleaning dirty unpinned ones; a stall holds it.
// Reset clears valid bits and counters, presets the registers; no clearing pass is needed.
// A full result register stalls the sequencer; one new request is taken per
// finished request, also while the last result still waits.
module buffer_pool_frame_directory_top
  import bpfd_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam logic [8:0]  NF9 = 9'(NUM_FRAMES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_ACT   = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FEND  = 4'd7;

  logic [3:0]        state_q, state_d;
  logic              mode_q;
  logic [4:0]        fiu_q;
  logic [CW-1:0]     n_q;
  logic [8:0]        n9;
  req_t              req_q;
  logic [CW-1:0]     scan_q, scan_d;
  logic [IW-1:0]     lp_q, lp_d;
  logic [IW-1:0]     start_q;
  logic [IW-1:0]     tgt_q, tgt_d;
  logic              hit_q, hit_d, none_q, none_d, evict_q, evict_d;
  logic [StampW-1:0] stamp_ctr_q, stamp_ctr_d;
  logic [TotW-1:0]   reads_q, reads_d, writes_q, writes_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              hold_vld_q, hold_vld_d;
  rsp_t              hold_q, hold_d;
  logic              out_vld_q, out_vld_d;
  rsp_t              out_q, out_d;
  logic              out_free;

  entry_t            mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  entry_t            rdata_q;
  logic [IW-1:0]     rd_idx_q;
  logic              cmp_en_q;
  logic              we;
  logic [IW-1:0]     wa;
  entry_t            wd;
  entry_t            ent;
  logic              ent_vld;

  scan_t             scan_res;
  logic              scan_clr;
  logic              cfg_we;
  logic [StampW-1:0] stamp_next;
  logic [IW-1:0]     vict_nxt;
  logic              cand;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FRAMES) ? {27'd0, fiu_q} : {31'd0, mode_q};

  always_comb begin
    if (fiu_q == 5'd0) begin
      n9 = 9'd1;
    end else if ({4'd0, fiu_q} > NF9) begin
      n9 = NF9;
    end else begin
      n9 = {4'd0, fiu_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      fiu_q  <= 5'd16;
      n_q    <= '0;
    end else begin
      if (cfg_we && (paddr[2] == REG_MODE)) begin
        mode_q <= pwdata[0];
      end
      if (cfg_we && (paddr[2] == REG_FRAMES)) begin
        fiu_q <= pwdata[4:0];
      end
      n_q <= n9[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_idx_q <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[wa] <= 1'b1;
      end
      if (rd_en) begin
        rd_idx_q <= rd_addr;
      end
      cmp_en_q <= (state_q == S_SCAN);
    end
  end

  // frames never written read as the reset entry
  assign ent_vld = valid_q[rd_idx_q];
  assign ent     = ent_vld ? rdata_q : '0;

  assign scan_clr = req_valid_i && req_ready_o;

  bpfd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (scan_clr),
    .en_i    (cmp_en_q),
    .idx_i   (8'(rd_idx_q)),
    .vld_i   (ent_vld),
    .ent_i   (rdata_q),
    .page_i  (req_q.page_number),
    .start_i (8'(start_q)),
    .res_o   (scan_res)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign out_free    = !out_vld_q || rsp_ready_i;
  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;
  assign stamp_next  = (stamp_ctr_q == '1) ? stamp_ctr_q : stamp_ctr_q + 1'b1;
  assign vict_nxt    = ({1'b0, tgt_q} + 1'b1 == {1'b0, n_q[IW-1:0]}) ||
                       (CW'(tgt_q) + 1'b1 == n_q) ? '0 : tgt_q + 1'b1;
  assign cand = ent_vld && (ent.pin == '0) && ent.dirty;

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    lp_d        = lp_q;
    tgt_d       = tgt_q;
    hit_d       = hit_q;
    none_d      = none_q;
    evict_d     = evict_q;
    stamp_ctr_d = stamp_ctr_q;
    reads_d     = reads_q;
    writes_d    = writes_q;
    cnt_d       = cnt_q;
    hold_vld_d  = hold_vld_q;
    hold_d      = hold_q;
    out_vld_d   = out_vld_q && !rsp_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q[IW-1:0];
    we          = 1'b0;
    wa          = tgt_q;
    wd          = ent;

    unique case (state_q)
      S_IDLE: begin
        scan_d     = '0;
        cnt_d      = '0;
        hold_vld_d = 1'b0;
        if (req_valid_i) begin
          priority if (req_i.req_type == REQ_FLUSH) begin
            state_d = S_FRD;
          end else if (req_i.req_type > REQ_FLUSH) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en  = 1'b1;
        scan_d = scan_q + 1'b1;
        if (scan_q + 1'b1 == n_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        hit_d   = scan_res.hit_found;
        evict_d = 1'b0;
        none_d  = 1'b0;
        tgt_d   = IW'(scan_res.hit_idx);
        if (req_q.req_type == REQ_PIN && !scan_res.hit_found) begin
          priority if (scan_res.empty_found) begin
            tgt_d = IW'(scan_res.empty_idx);
          end else if (mode_q) begin
            evict_d = scan_res.lru_found;
            none_d  = !scan_res.lru_found;
            tgt_d   = IW'(scan_res.lru_idx);
          end else if (scan_res.ffhi_found) begin
            evict_d = 1'b1;
            tgt_d   = IW'(scan_res.ffhi_idx);
          end else begin
            evict_d = scan_res.fflo_found;
            none_d  = !scan_res.fflo_found;
            tgt_d   = IW'(scan_res.fflo_idx);
          end
        end else if (!scan_res.hit_found) begin
          none_d = 1'b1;
        end
        rd_en   = 1'b1;
        rd_addr = tgt_d;
        state_d = S_ACT;
      end
      S_ACT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = '0;
          out_d.last = 1'b1;
          state_d   = S_IDLE;
          if (none_q) begin
            out_d.status = (req_q.req_type == REQ_PIN) ? ST_NO_VICT : ST_MISSING;
          end else begin
            out_d.frame_index = 4'(tgt_q);
            we = 1'b1;
            unique case (req_q.req_type)
              REQ_PIN: begin
                stamp_ctr_d = stamp_next;
                if (hit_q) begin
                  out_d.was_hit = 1'b1;
                  if (ent.pin != PIN_MAX) begin
                    wd.pin = ent.pin + 1'b1;
                  end
                  if (mode_q) begin
                    wd.stamp = stamp_next;
                  end
                end else begin
                  out_d.fetch_page = 1'b1;
                  wd.page  = req_q.page_number;
                  wd.pin   = 8'd1;
                  wd.dirty = 1'b0;
                  if (mode_q) begin
                    wd.stamp = stamp_next;
                  end
                  if (reads_q != TOT_MAX) begin
                    reads_d = reads_q + 1'b1;
                  end
                  if (ent_vld && ent.dirty) begin
                    out_d.write_back        = 1'b1;
                    out_d.write_page_number = ent.page;
                    if (writes_q != TOT_MAX) begin
                      writes_d = writes_q + 1'b1;
                    end
                  end
                  if (evict_q && !mode_q) begin
                    lp_d = vict_nxt;
                  end
                end
              end
              REQ_UNPIN: begin
                if (ent.pin != '0) begin
                  wd.pin = ent.pin - 1'b1;
                end
              end
              REQ_DIRTY: begin
                wd.dirty = 1'b1;
              end
              default: begin
                wd.dirty                = 1'b0;
                out_d.write_back        = 1'b1;
                out_d.write_page_number = ent.page;
                if (writes_q != TOT_MAX) begin
                  writes_d = writes_q + 1'b1;
                end
              end
            endcase
          end
          out_d.read_total  = reads_d;
          out_d.write_total = writes_d;
        end
      end
      S_FRD: begin
        if (scan_q == n_q || cnt_q == 5'(MaxRsp)) begin
          state_d = S_FEND;
        end else begin
          rd_en   = 1'b1;
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!cand) begin
          scan_d  = scan_q + 1'b1;
          state_d = S_FRD;
        end else if (!hold_vld_q || out_free) begin
          // release the held beat, keep this one until the next is known
          if (hold_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = hold_q;
          end
          we       = 1'b1;
          wa       = rd_idx_q;
          wd.dirty = 1'b0;
          if (writes_q != TOT_MAX) begin
            writes_d = writes_q + 1'b1;
          end
          hold_vld_d = 1'b1;
          hold_d     = '0;
          hold_d.frame_index       = 4'(rd_idx_q);
          hold_d.write_back        = 1'b1;
          hold_d.write_page_number = ent.page;
          hold_d.read_total        = reads_q;
          hold_d.write_total       = writes_d;
          cnt_d   = cnt_q + 1'b1;
          scan_d  = scan_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_FEND: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (hold_vld_q) begin
            out_d = hold_q;
          end else begin
            out_d             = '0;
            out_d.read_total  = reads_q;
            out_d.write_total = writes_q;
          end
          out_d.last = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      lp_q        <= '0;
      start_q     <= '0;
      tgt_q       <= '0;
      hit_q       <= 1'b0;
      none_q      <= 1'b0;
      evict_q     <= 1'b0;
      stamp_ctr_q <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
      cnt_q       <= '0;
      hold_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      lp_q        <= lp_d;
      tgt_q       <= tgt_d;
      hit_q       <= hit_d;
      none_q      <= none_d;
      evict_q     <= evict_d;
      stamp_ctr_q <= stamp_ctr_d;
      reads_q     <= reads_d;
      writes_q    <= writes_d;
      cnt_q       <= cnt_d;
      hold_vld_q  <= hold_vld_d;
      out_vld_q   <= out_vld_d;
      // use the live frame count, a write just before the request may not be in n_q yet
      if (scan_clr) begin
        start_q <= (9'(lp_q) < n9) ? lp_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_clr) begin
      req_q <= req_i;
    end
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

[rtl/core/bpfd_checker.sv]
module bpfd_checker
  import bpfd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o,
  input logic pready
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result beat dropped or changed while stalled");

  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.fetch_page |-> rsp_o.status == ST_OK && !rsp_o.was_hit)
    else $error("fetch on an error or hit result");

  a_wpage_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.write_back |-> rsp_o.write_page_number == '0)
    else $error("write page set without write back");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_OK |-> rsp_o.last && !rsp_o.write_back)
    else $error("error result not final");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind buffer_pool_frame_directory_top bpfd_checker u_bpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o),
  .pready      (pready)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bpfd_pkg::*;

  localparam int NumFrames = 16;
  localparam int CycleLimit = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  buffer_pool_frame_directory_top #(.NUM_FRAMES(NumFrames)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Directory mirror
  logic              fr_valid [NumFrames];
  logic [PageW-1:0]  fr_page  [NumFrames];
  logic [PinW-1:0]   fr_pin   [NumFrames];
  logic              fr_dirty [NumFrames];
  logic [StampW-1:0] fr_stamp [NumFrames];
  logic [StampW-1:0] stamp_ctr;
  int                fifo_ptr;
  logic [TotW-1:0]   loads, stores;
  logic              lru_mode;
  logic [4:0]        frame_cnt;

  rsp_t pending_rsp[$];
  int   errors;
  int   cycles;
  logic rsp_stall_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic int active_cnt();
    if (frame_cnt == 0) return 1;
    if (frame_cnt > NumFrames) return NumFrames;
    return frame_cnt;
  endfunction

  function automatic int find_page(logic [PageW-1:0] pg);
    int n;
    n = active_cnt();
    for (int i = 0; i < n; i++)
      if (fr_valid[i] && fr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic rsp_t mk_rsp(int fi, logic [1:0] st, logic hit, logic fe, logic wb,
                                  logic [PageW-1:0] wp, logic lst);
    rsp_t r;
    r.frame_index = fi[3:0];
    r.status = st;
    r.was_hit = hit;
    r.fetch_page = fe;
    r.write_back = wb;
    r.write_page_number = wb ? wp : '0;
    r.read_total = loads;
    r.write_total = stores;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_directory(req_t rq);
    int n, f, v, st;
    logic wb;
    logic [PageW-1:0] wp;
    logic [StampW-1:0] best;
    int k;
    n = active_cnt();
    f = find_page(rq.page_number);
    wb = 1'b0;
    wp = '0;
    v = -1;
    case (rq.req_type)
      REQ_PIN: begin
        if (f >= 0) begin
          if (fr_pin[f] != PIN_MAX) fr_pin[f]++;
          stamp_ctr = sat_up(stamp_ctr);
          if (lru_mode) fr_stamp[f] = stamp_ctr;
          pending_rsp.push_back(mk_rsp(f, ST_OK, 1'b1, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            if (!fr_valid[i]) begin
              v = i;
              break;
            end
          if (v < 0) begin
            if (lru_mode) begin
              best = '0;
              for (int i = 0; i < n; i++)
                if (fr_pin[i] == 0 && (v < 0 || fr_stamp[i] < best)) begin
                  v = i;
                  best = fr_stamp[i];
                end
            end else begin
              st = (fifo_ptr < n) ? fifo_ptr : 0;
              for (int i = 0; i < n; i++)
                if (fr_pin[(st + i) % n] == 0) begin
                  v = (st + i) % n;
                  break;
                end
              if (v >= 0) fifo_ptr = (v + 1) % n;
            end
            if (v < 0) begin
              pending_rsp.push_back(mk_rsp(0, ST_NO_VICT, 1'b0, 1'b0, 1'b0, '0, 1'b1));
              return;
            end
            if (fr_dirty[v]) begin
              wb = 1'b1;
              wp = fr_page[v];
              stores = sat_up(stores);
            end
          end
          fr_valid[v] = 1'b1;
          fr_page[v] = rq.page_number;
          fr_pin[v] = 1;
          fr_dirty[v] = 1'b0;
          stamp_ctr = sat_up(stamp_ctr);
          if (lru_mode) fr_stamp[v] = stamp_ctr;
          loads = sat_up(loads);
          pending_rsp.push_back(mk_rsp(v, ST_OK, 1'b0, 1'b1, wb, wp, 1'b1));
        end
      end
      REQ_FLUSH: begin
        k = 0;
        for (int i = 0; i < n && k < MaxRsp; i++)
          if (fr_valid[i] && fr_pin[i] == 0 && fr_dirty[i]) begin
            fr_dirty[i] = 1'b0;
            stores = sat_up(stores);
            pending_rsp.push_back(mk_rsp(i, ST_OK, 1'b0, 1'b0, 1'b1, fr_page[i], 1'b0));
            k++;
          end
        if (k == 0) pending_rsp.push_back(mk_rsp(0, ST_OK, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        else pending_rsp[$].last = 1'b1;
      end
      REQ_UNPIN, REQ_DIRTY, REQ_FORCE: begin
        if (f < 0) begin
          pending_rsp.push_back(mk_rsp(0, ST_MISSING, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        end else if (rq.req_type == REQ_UNPIN) begin
          if (fr_pin[f] != 0) fr_pin[f]--;
          pending_rsp.push_back(mk_rsp(f, ST_OK, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        end else if (rq.req_type == REQ_DIRTY) begin
          fr_dirty[f] = 1'b1;
          pending_rsp.push_back(mk_rsp(f, ST_OK, 1'b0, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          fr_dirty[f] = 1'b0;
          stores = sat_up(stores);
          pending_rsp.push_back(mk_rsp(f, ST_OK, 1'b0, 1'b0, 1'b1, fr_page[f], 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", 32'(rsp_o.frame_index), 32'hx);
      end else begin
        w = pending_rsp.pop_front();
        if (rsp_o.frame_index !== w.frame_index)
          report_mismatch("frame_index", 32'(rsp_o.frame_index), 32'(w.frame_index));
        if (rsp_o.status !== w.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(w.status));
        if (rsp_o.was_hit !== w.was_hit)
          report_mismatch("was_hit", 32'(rsp_o.was_hit), 32'(w.was_hit));
        if (rsp_o.fetch_page !== w.fetch_page)
          report_mismatch("fetch_page", 32'(rsp_o.fetch_page), 32'(w.fetch_page));
        if (rsp_o.write_back !== w.write_back)
          report_mismatch("write_back", 32'(rsp_o.write_back), 32'(w.write_back));
        if (rsp_o.write_page_number !== w.write_page_number)
          report_mismatch("write_page_number", 32'(rsp_o.write_page_number),
                          32'(w.write_page_number));
        if (rsp_o.read_total !== w.read_total)
          report_mismatch("read_total", rsp_o.read_total, w.read_total);
        if (rsp_o.write_total !== w.write_total)
          report_mismatch("write_total", rsp_o.write_total, w.write_total);
        if (rsp_o.last !== w.last)
          report_mismatch("last", 32'(rsp_o.last), 32'(w.last));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls, with stretches of steady ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      rsp_stall_on <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) rsp_stall_on <= ~rsp_stall_on;
      if (!rsp_stall_on) rsp_ready_i <= 1'b1;
      else rsp_ready_i <= ($urandom_range(0, 9) < 6) ? 1'b1 : (pick_gap() < 2);
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    req_valid_i <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODE) lru_mode = val[0];
    else frame_cnt = val[4:0];
    @(posedge clk_i);
  endtask

  // valid stays up after the accepting edge; the next caller drops or reloads it
  task automatic send_request(logic [2:0] rt, logic [PageW-1:0] pg);
    req_t rq;
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.req_type = rt;
    rq.page_number = pg;
    req_valid_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    predict_directory(rq);
  endtask

  task automatic settle();
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  typedef struct {
    logic [2:0]       rt;
    logic [PageW-1:0] pg;
    logic             typed;
    rsp_t             want;
  } dir_row_t;

  function automatic rsp_t fixed_rsp(int fi, logic [1:0] st, logic hit, logic fe, logic wb,
                                     logic [PageW-1:0] wp, int rd, int wr);
    rsp_t r;
    r = '{frame_index: fi[3:0], status: st, was_hit: hit, fetch_page: fe,
          write_back: wb, write_page_number: wp, read_total: rd, write_total: wr,
          last: 1'b1};
    return r;
  endfunction

  function automatic logic [PageW-1:0] rand_page(int pool);
    if ($urandom_range(0, 9) == 0) return PageW'($urandom);
    return PageW'($urandom_range(0, pool));
  endfunction

  function automatic logic [2:0] rand_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REQ_PIN;
    if (r < 70) return REQ_UNPIN;
    if (r < 84) return REQ_DIRTY;
    if (r < 92) return REQ_FORCE;
    if (r < 97) return REQ_FLUSH;
    return 3'($urandom_range(5, 7));
  endfunction

  dir_row_t dir_rows[$];
  rsp_t     snap_want;

  initial begin
    int pool;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NumFrames; i++) begin
      fr_valid[i] = 1'b0;
      fr_page[i] = '0;
      fr_pin[i] = '0;
      fr_dirty[i] = 1'b0;
      fr_stamp[i] = '0;
    end
    stamp_ctr = '0;
    fifo_ptr = 0;
    loads = '0;
    stores = '0;
    lru_mode = 1'b0;
    frame_cnt = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two frames, FIFO, then LRU
    reg_write(REG_FRAMES, 32'd2);
    dir_rows = '{
      '{REQ_UNPIN, 24'h000000, 1'b1,
        fixed_rsp(0, ST_MISSING, 1'b0, 1'b0, 1'b0, '0, 0, 0)},
      '{REQ_FLUSH, 24'h000000, 1'b1,
        fixed_rsp(0, ST_OK, 1'b0, 1'b0, 1'b0, '0, 0, 0)},
      '{REQ_PIN,   24'hFFFFFF, 1'b1,
        fixed_rsp(0, ST_OK, 1'b0, 1'b1, 1'b0, '0, 1, 0)},
      '{REQ_PIN,   24'h000000, 1'b1,
        fixed_rsp(1, ST_OK, 1'b0, 1'b1, 1'b0, '0, 2, 0)},
      '{REQ_PIN,   24'hFFFFFF, 1'b1,
        fixed_rsp(0, ST_OK, 1'b1, 1'b0, 1'b0, '0, 2, 0)},
      '{REQ_PIN,   24'h123456, 1'b1,
        fixed_rsp(0, ST_NO_VICT, 1'b0, 1'b0, 1'b0, '0, 2, 0)},
      '{REQ_DIRTY, 24'hFFFFFF, 1'b0, '0},
      '{REQ_FLUSH, 24'h000000, 1'b0, '0},
      '{REQ_UNPIN, 24'hFFFFFF, 1'b0, '0},
      '{REQ_UNPIN, 24'hFFFFFF, 1'b0, '0},
      '{REQ_UNPIN, 24'hFFFFFF, 1'b0, '0},
      '{REQ_FLUSH, 24'h000000, 1'b0, '0},
      '{REQ_PIN,   24'h0AAAAA, 1'b0, '0},
      '{REQ_DIRTY, 24'h0AAAAA, 1'b0, '0},
      '{REQ_FORCE, 24'h0AAAAA, 1'b0, '0},
      '{REQ_FORCE, 24'h555555, 1'b0, '0},
      '{3'd7,      24'h000001, 1'b0, '0},
      '{REQ_UNPIN, 24'h000000, 1'b0, '0},
      '{REQ_UNPIN, 24'h0AAAAA, 1'b0, '0},
      '{REQ_DIRTY, 24'h0AAAAA, 1'b0, '0},
      '{REQ_PIN,   24'h000777, 1'b0, '0},
      '{REQ_FLUSH, 24'h000000, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].rt, dir_rows[i].pg);
      if (dir_rows[i].typed) begin
        snap_want = pending_rsp[$];
        if (snap_want !== dir_rows[i].want)
          report_mismatch("directed row", i, 32'(dir_rows[i].rt));
      end
    end
    settle();
    reg_write(REG_MODE, 32'd1);
    for (int i = 0; i < 3; i++) send_request(REQ_PIN, 24'(i + 100));
    send_request(REQ_UNPIN, 24'd100);
    send_request(REQ_UNPIN, 24'd0);
    send_request(REQ_PIN, 24'd200);
    settle();

    // Random phases over mode and frame count, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: frame_cnt = 5'd1;
        1: frame_cnt = 5'd16;
        2: frame_cnt = 5'd0;
        3: frame_cnt = 5'd31;
        default: frame_cnt = 5'($urandom_range(1, 16));
      endcase
      reg_write(REG_FRAMES, 32'(frame_cnt));
      reg_write(REG_MODE, 32'(ph % 2));
      pool = (active_cnt() * 3) / 2 + 1;
      for (int i = 0; i < 50; i++) send_request(rand_req(), rand_page(pool));
      settle();
    end

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bpfd_pkg.sv
rtl/core/bpfd_scan.sv
rtl/core/buffer_pool_frame_directory_top.sv
rtl/core/bpfd_checker.sv
tb/tb_top.sv
